>>> hw/rtl/sutc_pkg.sv
package sutc_pkg;

    // Field widths
    localparam int CH_IDX_W   = 4;
    localparam int LEVEL_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 5;
    localparam int PULSE_W    = 8;

    // Build constants
    localparam int DEFAULT_CHANNELS = 16;
    localparam int MAX_CHANNELS     = 16;
    localparam int PULSE_TICKS      = 48;
    localparam int CLIP_LIMIT       = 12000;
    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;
    localparam logic [CNT_W-1:0] MIN_CNT_FLOOR = 5'd1;
    localparam logic [CNT_W-1:0] MIN_CNT_CEIL  = 5'd16;

    // Operating mode codes (any code with bit 1 set counts triggers)
    localparam logic [1:0] MODE_VALUE = 2'd0;
    localparam logic [1:0] MODE_GATE  = 2'd1;
    localparam logic [1:0] MODE_COUNT = 2'd2;

    // Count clear codes
    localparam logic [1:0] CLR_ON_RESET  = 2'd0;
    localparam logic [1:0] CLR_ON_UPDATE = 2'd1;

    // Register reset values
    localparam logic [1:0]            RST_MODE       = MODE_VALUE;
    localparam logic [2:0]            RST_STYLE      = 3'd0;
    localparam logic [2:0]            RST_POLICY     = 3'd5;
    localparam logic [CNT_W-1:0]      RST_MIN_COUNT  = 5'd1;
    localparam logic [LEVEL_W-1:0]    RST_RESET_LVL  = 15'd0;
    localparam logic [LEVEL_W-1:0]    RST_DETECT_LO  = 15'd100;
    localparam logic [LEVEL_W-1:0]    RST_DETECT_HI  = 15'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_OUT_LEVELS = 32'h2710_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPERATING_MODE = 3'd0,
        CFG_CONTROL_STYLE  = 3'd1,
        CFG_RESET_POLICY   = 3'd2,
        CFG_MIN_COUNT      = 3'd3,
        CFG_RESET_LEVEL    = 3'd4,
        CFG_DETECT_LOW     = 3'd5,
        CFG_DETECT_HIGH    = 3'd6,
        CFG_OUT_LEVELS     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]                operating_mode;
        logic [2:0]                control_style;
        logic [2:0]                reset_policy;
        logic [CNT_W-1:0]          min_count;
        logic signed [LEVEL_W-1:0] reset_level;
        logic signed [LEVEL_W-1:0] detect_low;
        logic signed [LEVEL_W-1:0] detect_high;
        logic [CFG_DATA_W-1:0]     out_levels;
    } t_cfg;

    // Qualified control flags, shared by all channels until the next channel 0 request
    typedef struct packed {
        logic do_clear;
        logic do_update;
        logic do_sample;
    } t_tick;

    typedef struct packed {
        logic armed;
        logic hit;
    } t_schmitt;

    // Schmitt edge detector step
    function automatic t_schmitt schmitt_step(
        input logic                      armed,
        input logic signed [LEVEL_W-1:0] level,
        input logic signed [LEVEL_W-1:0] lo,
        input logic signed [LEVEL_W-1:0] hi
    );
        t_schmitt r;
        r.armed = armed;
        r.hit   = 1'b0;
        if (armed) begin
            if (level <= lo) r.armed = 1'b0;
        end else if (level >= hi) begin
            r.armed = 1'b1;
            r.hit   = 1'b1;
        end
        return r;
    endfunction

    // Clip a 16-bit level to the symmetric output range
    function automatic logic signed [LEVEL_W-1:0] clip_level(input logic signed [15:0] v);
        logic signed [15:0] lim_hi;
        logic signed [15:0] lim_lo;
        lim_hi = 16'(CLIP_LIMIT);
        lim_lo = -lim_hi;
        if (v > lim_hi)      return lim_hi[LEVEL_W-1:0];
        else if (v < lim_lo) return lim_lo[LEVEL_W-1:0];
        else                 return v[LEVEL_W-1:0];
    endfunction

    // Effective trigger threshold
    function automatic logic [CNT_W-1:0] eff_min(input logic [CNT_W-1:0] m);
        if (m < MIN_CNT_FLOOR)     return MIN_CNT_FLOOR;
        else if (m > MIN_CNT_CEIL) return MIN_CNT_CEIL;
        else                       return m;
    endfunction

endpackage

>>> hw/rtl/sample_update_trigger_counter_top.sv
// Polyphonic sample/update unit with trigger counter. Requests carry one
// channel's CV and the sample, update and reset control levels; channel 0
// requests qualify the controls, later channels reuse them. The block takes
// one request per clock unless a held result backs up both registers: a
// request waits in the input register, and all per-channel state (held
// sample, edge count, pulse counter, output hold) is read and rewritten in
// flip-flops as its result is written into the output register, where it
// stays until taken. The input register can take the next request while a
// finished result waits, but only if it is empty.
// Configuration writes are accepted every cycle and take effect at once;
// write them only while no request is in flight.
module sample_update_trigger_counter_top
    import sutc_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    // Request channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [CH_IDX_W-1:0]       i_channel,
    input  logic signed [LEVEL_W-1:0] i_cv_level,
    input  logic signed [LEVEL_W-1:0] i_sample_level,
    input  logic signed [LEVEL_W-1:0] i_update_level,
    input  logic signed [LEVEL_W-1:0] i_clear_level,
    // Result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [CH_IDX_W-1:0]       o_out_channel,
    output logic signed [LEVEL_W-1:0] o_out_level,
    output logic                      o_count_reached
);

    t_cfg  cfg;
    t_tick tick;

    // Input register
    logic                      r_s1_valid;
    logic [CH_IDX_W-1:0]       r_s1_channel;
    logic signed [LEVEL_W-1:0] r_s1_cv;
    logic signed [LEVEL_W-1:0] r_s1_sample;
    logic signed [LEVEL_W-1:0] r_s1_update;
    logic signed [LEVEL_W-1:0] r_s1_clear;

    // Result register
    logic                      r_out_valid;
    logic [CH_IDX_W-1:0]       r_out_channel;
    logic signed [LEVEL_W-1:0] r_out_level;
    logic                      r_out_reached;

    logic                      advance;
    logic                      fire;
    logic signed [LEVEL_W-1:0] core_level;
    logic                      core_reached;

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_s1_valid && advance;
    assign o_in_ready = !r_s1_valid || advance;

    sutc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sutc_ctrl_qual u_qual (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_channel      (r_s1_channel),
        .i_sample_level (r_s1_sample),
        .i_update_level (r_s1_update),
        .i_clear_level  (r_s1_clear),
        .i_cfg          (cfg),
        .o_tick         (tick)
    );

    sutc_chan_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_channel       (r_s1_channel),
        .i_cv_level      (r_s1_cv),
        .i_tick          (tick),
        .i_cfg           (cfg),
        .o_level         (core_level),
        .o_count_reached (core_reached)
    );

    // Capture a request into the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_channel <= i_channel;
            r_s1_cv      <= i_cv_level;
            r_s1_sample  <= i_sample_level;
            r_s1_update  <= i_update_level;
            r_s1_clear   <= i_clear_level;
        end
    end

    // Advance the result into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_channel <= r_s1_channel;
            r_out_level   <= core_level;
            r_out_reached <= core_reached;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_channel   = r_out_channel;
    assign o_out_level     = r_out_level;
    assign o_count_reached = r_out_reached;

    // Input stalls only when both registers are full and the result is held
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_out_valid && !i_out_ready)
        else $error("input stalled with room in the pipeline");

    // A stalled request keeps its place in the input register
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> r_s1_valid && $stable(r_s1_channel))
        else $error("stalled request lost from input register");

endmodule

>>> hw/rtl/sutc_cfg_regs.sv
module sutc_cfg_regs
    import sutc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.operating_mode <= RST_MODE;
            r_cfg.control_style  <= RST_STYLE;
            r_cfg.reset_policy   <= RST_POLICY;
            r_cfg.min_count      <= RST_MIN_COUNT;
            r_cfg.reset_level    <= RST_RESET_LVL;
            r_cfg.detect_low     <= RST_DETECT_LO;
            r_cfg.detect_high    <= RST_DETECT_HI;
            r_cfg.out_levels     <= RST_OUT_LEVELS;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OPERATING_MODE: r_cfg.operating_mode <= i_cfg_data[1:0];
                CFG_CONTROL_STYLE:  r_cfg.control_style  <= i_cfg_data[2:0];
                CFG_RESET_POLICY:   r_cfg.reset_policy   <= i_cfg_data[2:0];
                CFG_MIN_COUNT:      r_cfg.min_count      <= i_cfg_data[CNT_W-1:0];
                CFG_RESET_LEVEL:    r_cfg.reset_level    <= i_cfg_data[LEVEL_W-1:0];
                CFG_DETECT_LOW:     r_cfg.detect_low     <= i_cfg_data[LEVEL_W-1:0];
                CFG_DETECT_HIGH:    r_cfg.detect_high    <= i_cfg_data[LEVEL_W-1:0];
                CFG_OUT_LEVELS:     r_cfg.out_levels     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/sutc_ctrl_qual.sv
module sutc_ctrl_qual
    import sutc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic [CH_IDX_W-1:0]       i_channel,
    input  logic signed [LEVEL_W-1:0] i_sample_level,
    input  logic signed [LEVEL_W-1:0] i_update_level,
    input  logic signed [LEVEL_W-1:0] i_clear_level,
    input  t_cfg                      i_cfg,
    output t_tick                     o_tick
);

    logic [2:0]                r_armed;
    logic [2:0]                n_armed;
    t_tick                     r_tick;
    t_tick                     n_tick;
    logic                      is_ch0;
    logic signed [LEVEL_W-1:0] lv [3];
    logic [2:0]                hits;
    t_schmitt                  st;

    assign is_ch0 = (i_channel == '0);
    assign lv[0]  = i_sample_level;
    assign lv[1]  = i_update_level;
    assign lv[2]  = i_clear_level;

    // Qualify each control as a gate level or a Schmitt edge
    always_comb begin
        n_armed = r_armed;
        hits    = '0;
        for (int k = 0; k < 3; k++) begin
            st = schmitt_step(r_armed[k], lv[k], i_cfg.detect_low, i_cfg.detect_high);
            if (i_cfg.control_style[k]) begin
                hits[k] = (lv[k] >= i_cfg.detect_high);
            end else begin
                hits[k]    = st.hit;
                n_armed[k] = st.armed;
            end
        end
        n_tick.do_sample = hits[0];
        n_tick.do_update = hits[1];
        n_tick.do_clear  = hits[2];
    end

    // Channel 0 refreshes the flags, others reuse the last ones
    assign o_tick = is_ch0 ? n_tick : r_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= '0;
            r_tick  <= '0;
        end else if (i_fire && is_ch0) begin
            r_armed <= n_armed;
            r_tick  <= n_tick;
        end
    end

    // Flags only move on a channel 0 request
    a_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_fire && is_ch0) |=> $stable(r_tick) && $stable(r_armed))
        else $error("control flags changed without a channel 0 request");

    // A gate-style sample control never touches its edge detector
    a_gate_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && is_ch0 && i_cfg.control_style[0]) |=> $stable(r_armed[0]))
        else $error("gate-style sample control changed its detector");

endmodule

>>> hw/rtl/sutc_chan_core.sv
module sutc_chan_core
    import sutc_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic [CH_IDX_W-1:0]       i_channel,
    input  logic signed [LEVEL_W-1:0] i_cv_level,
    input  t_tick                     i_tick,
    input  t_cfg                      i_cfg,
    output logic signed [LEVEL_W-1:0] o_level,
    output logic                      o_count_reached
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_IDX_W:0] CH_LIMIT = (CH_IDX_W+1)'(CHANNELS);

    // Per-channel state
    logic signed [LEVEL_W-1:0] r_held  [CHANNELS];
    logic [CNT_W-1:0]          r_cnt   [CHANNELS];
    logic                      r_armed [CHANNELS];
    logic [PULSE_W-1:0]        r_pulse [CHANNELS];
    logic signed [LEVEL_W-1:0] r_hold  [CHANNELS];

    logic signed [LEVEL_W-1:0] n_held;
    logic [CNT_W-1:0]          n_cnt;
    logic                      n_armed;
    logic [PULSE_W-1:0]        n_pulse;
    logic signed [LEVEL_W-1:0] n_hold;

    logic [CH_W-1:0]           idx;
    logic                      in_range;
    logic [CNT_W-1:0]          min_eff;
    logic [1:0]                clr_code;
    logic signed [15:0]        lvl_hi;
    logic signed [15:0]        lvl_lo;
    logic                      running;
    logic [CNT_W-1:0]          cnt_edge;
    logic [PULSE_W-1:0]        pulse_dec;
    logic signed [LEVEL_W-1:0] gate_src;
    t_schmitt                  st;

    assign idx      = i_channel[CH_W-1:0];
    assign in_range = ({1'b0, i_channel} < CH_LIMIT);
    assign min_eff  = eff_min(i_cfg.min_count);
    assign clr_code = i_cfg.reset_policy[2:1];
    assign lvl_hi   = i_cfg.out_levels[31:16];
    assign lvl_lo   = i_cfg.out_levels[15:0];

    // Next state of the addressed channel
    always_comb begin
        n_held   = r_held[idx];
        n_cnt    = r_cnt[idx];
        n_armed  = r_armed[idx];
        n_pulse  = r_pulse[idx];
        n_hold   = r_hold[idx];
        running  = (r_pulse[idx] != '0);
        cnt_edge = r_cnt[idx];
        st       = schmitt_step(r_armed[idx], i_cv_level, i_cfg.detect_low,
                                i_cfg.detect_high);
        gate_src = i_tick.do_clear ? i_cfg.reset_level :
                   (i_tick.do_sample ? i_cv_level : r_held[idx]);
        pulse_dec = running ? r_pulse[idx] - 1'b1 : r_pulse[idx];

        if (i_cfg.operating_mode[1]) begin
            // Count rising edges on sample, fire a pulse on update, clear on reset
            if (i_tick.do_clear) begin
                n_held  = i_cfg.reset_level;
                n_armed = 1'b0;
            end else if (i_tick.do_sample) begin
                n_held  = i_cv_level;
                n_armed = st.armed;
                if (st.hit && (r_cnt[idx] < CNT_MAX)) cnt_edge = r_cnt[idx] + 1'b1;
            end
            n_cnt   = cnt_edge;
            n_pulse = pulse_dec;
            if (i_tick.do_clear && (clr_code != CLR_ON_UPDATE)) begin
                n_cnt   = '0;
                n_pulse = '0;
            end else if ((cnt_edge >= min_eff) && i_tick.do_update && !running) begin
                n_pulse = PULSE_W'(PULSE_TICKS);
                if (clr_code != CLR_ON_RESET) n_cnt = '0;
            end
            n_hold = clip_level((n_pulse != '0) ? lvl_hi : lvl_lo);
        end else begin
            // Hold the sample, refresh the output on update or, if policy bit 0 is set, on reset
            n_held = gate_src;
            if (i_tick.do_update || (i_tick.do_clear && i_cfg.reset_policy[0])) begin
                if (i_cfg.operating_mode == MODE_GATE)
                    n_hold = clip_level((gate_src >= i_cfg.detect_high) ? lvl_hi : lvl_lo);
                else
                    n_hold = clip_level({gate_src[LEVEL_W-1], gate_src});
            end
        end
    end

    assign o_level         = in_range ? n_hold : '0;
    assign o_count_reached = in_range && (n_cnt >= min_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_held[c]  <= '0;
                r_cnt[c]   <= '0;
                r_armed[c] <= 1'b0;
                r_pulse[c] <= '0;
                r_hold[c]  <= '0;
            end
        end else if (i_fire && in_range) begin
            r_held[idx]  <= n_held;
            r_cnt[idx]   <= n_cnt;
            r_armed[idx] <= n_armed;
            r_pulse[idx] <= n_pulse;
            r_hold[idx]  <= n_hold;
        end
    end

    // Count-mode clear outside update-only policy empties the channel
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && in_range && i_cfg.operating_mode[1] && i_tick.do_clear
         && (clr_code != CLR_ON_UPDATE))
        |=> (r_cnt[$past(idx)] == '0) && (r_pulse[$past(idx)] == '0))
        else $error("count mode clear left count or pulse behind");

    // A channel outside the range returns a quiet result
    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_range |-> (o_level == '0) && !o_count_reached)
        else $error("out of range channel produced a result");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

import sutc_pkg::*;

typedef struct packed {
    logic [CH_IDX_W-1:0]       channel;
    logic signed [LEVEL_W-1:0] cv;
    logic signed [LEVEL_W-1:0] sample_lvl;
    logic signed [LEVEL_W-1:0] update_lvl;
    logic signed [LEVEL_W-1:0] clear_lvl;
} cv_request_t;

typedef struct packed {
    logic [CH_IDX_W-1:0] channel;
    logic [LEVEL_W-1:0]  level;
    logic                reached;
} channel_output_t;

// Tracks held samples, edge counts and pulses per channel and the outputs they produce
class channel_level_tracker;
    logic [1:0]            mode;
    logic [2:0]            style;
    logic [2:0]            policy;
    logic [CNT_W-1:0]      min_cnt;
    int                    rst_lvl;
    int                    det_lo;
    int                    det_hi;
    logic [CFG_DATA_W-1:0] levels;

    int    held_cv    [MAX_CHANNELS];
    int    edge_cnt   [MAX_CHANNELS];
    bit    cv_armed   [MAX_CHANNELS];
    int    pulse_left [MAX_CHANNELS];
    int    out_hold   [MAX_CHANNELS];
    bit    ctrl_armed [3];
    t_tick ticks;

    channel_output_t due_outputs [$];
    int              mismatches;
    int              outputs_checked;

    function new();
        mode            = RST_MODE;
        style           = RST_STYLE;
        policy          = RST_POLICY;
        min_cnt         = RST_MIN_COUNT;
        rst_lvl         = int'($signed(RST_RESET_LVL));
        det_lo          = int'($signed(RST_DETECT_LO));
        det_hi          = int'($signed(RST_DETECT_HI));
        levels          = RST_OUT_LEVELS;
        ticks           = '0;
        mismatches      = 0;
        outputs_checked = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_OPERATING_MODE: mode    = data[1:0];
            CFG_CONTROL_STYLE:  style   = data[2:0];
            CFG_RESET_POLICY:   policy  = data[2:0];
            CFG_MIN_COUNT:      min_cnt = data[CNT_W-1:0];
            CFG_RESET_LEVEL:    rst_lvl = int'($signed(data[LEVEL_W-1:0]));
            CFG_DETECT_LOW:     det_lo  = int'($signed(data[LEVEL_W-1:0]));
            CFG_DETECT_HIGH:    det_hi  = int'($signed(data[LEVEL_W-1:0]));
            CFG_OUT_LEVELS:     levels  = data;
            default: ;
        endcase
    endfunction

    // Disarm at or below the low threshold, arm and report at or above the high one
    function bit edge_hit(inout bit armed, input int lvl);
        if (armed) begin
            if (lvl <= det_lo) armed = 1'b0;
            return 1'b0;
        end
        if (lvl >= det_hi) begin
            armed = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function int clip(int v);
        if (v > CLIP_LIMIT) return CLIP_LIMIT;
        if (v < -CLIP_LIMIT) return -CLIP_LIMIT;
        return v;
    endfunction

    function void take_request(cv_request_t r);
        int              ch;
        int              cv;
        int              lv [3];
        bit              hit [3];
        bit              armed;
        bit              running;
        int              high_out;
        int              low_out;
        int              v;
        int              need;
        logic [1:0]      clr;
        channel_output_t res;

        ch       = int'(r.channel);
        cv       = int'($signed(r.cv));
        lv[0]    = int'($signed(r.sample_lvl));
        lv[1]    = int'($signed(r.update_lvl));
        lv[2]    = int'($signed(r.clear_lvl));
        high_out = int'($signed(levels[31:16]));
        low_out  = int'($signed(levels[15:0]));
        if (min_cnt < MIN_CNT_FLOOR) need = MIN_CNT_FLOOR;
        else if (min_cnt > MIN_CNT_CEIL) need = MIN_CNT_CEIL;
        else need = min_cnt;

        // Qualify the controls on channel 0, hold them for the other channels
        if (ch == 0) begin
            for (int k = 0; k < 3; k++) begin
                if (style[k]) begin
                    hit[k] = lv[k] >= det_hi;
                end else begin
                    armed         = ctrl_armed[k];
                    hit[k]        = edge_hit(armed, lv[k]);
                    ctrl_armed[k] = armed;
                end
            end
            ticks.do_sample = hit[0];
            ticks.do_update = hit[1];
            ticks.do_clear  = hit[2];
        end

        res.channel = r.channel;
        res.level   = '0;
        res.reached = 1'b0;
        if (ch < DEFAULT_CHANNELS) begin
            clr = policy[2:1];
            if (mode >= MODE_COUNT) begin
                // Count rising edges of the sampled CV
                if (ticks.do_clear) begin
                    held_cv[ch]  = rst_lvl;
                    cv_armed[ch] = 1'b0;
                end else if (ticks.do_sample) begin
                    held_cv[ch] = cv;
                    armed       = cv_armed[ch];
                    if (edge_hit(armed, cv) && edge_cnt[ch] < CNT_MAX) edge_cnt[ch]++;
                    cv_armed[ch] = armed;
                end
                // Advance the pulse, then clear or fire
                running = pulse_left[ch] > 0;
                if (running) pulse_left[ch]--;
                if (ticks.do_clear && clr != CLR_ON_UPDATE) begin
                    edge_cnt[ch]   = 0;
                    pulse_left[ch] = 0;
                end else if (edge_cnt[ch] >= need && ticks.do_update && !running) begin
                    pulse_left[ch] = PULSE_TICKS;
                    if (clr != CLR_ON_RESET) edge_cnt[ch] = 0;
                end
                out_hold[ch] = clip(pulse_left[ch] > 0 ? high_out : low_out);
            end else begin
                // Hold the sample, refresh the output on update or, if policy bit 0 is set, on reset
                if (ticks.do_sample) held_cv[ch] = cv;
                if (ticks.do_clear) held_cv[ch] = rst_lvl;
                if (ticks.do_update || (ticks.do_clear && policy[0])) begin
                    v = held_cv[ch];
                    if (mode == MODE_GATE) v = (v >= det_hi) ? high_out : low_out;
                    out_hold[ch] = clip(v);
                end
            end
            res.level   = out_hold[ch][LEVEL_W-1:0];
            res.reached = edge_cnt[ch] >= need;
        end
        due_outputs.push_back(res);
    endfunction

    function void check_result(logic [CH_IDX_W-1:0] channel, logic [LEVEL_W-1:0] level,
                               logic reached);
        channel_output_t want;
        outputs_checked++;
        if (due_outputs.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing pending: channel %0d level %0d",
                     $time, channel, $signed(level));
            return;
        end
        want = due_outputs.pop_front();
        if (channel !== want.channel) begin
            mismatches++;
            $display("%0t: out_channel expected %0d, got %0d", $time, want.channel, channel);
        end
        if (level !== want.level) begin
            mismatches++;
            $display("%0t: out_level on channel %0d expected %0d, got %0d", $time,
                     want.channel, $signed(want.level), $signed(level));
        end
        if (reached !== want.reached) begin
            mismatches++;
            $display("%0t: count_reached on channel %0d expected %0b, got %0b", $time,
                     want.channel, want.reached, reached);
        end
    endfunction
endclass

module tb_top;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         IDLE_PCT        = 17;
    localparam int         LEVEL_MAX       = 16000;
    localparam logic [1:0] CLR_ON_BOTH     = 2'd2;
    localparam logic [1:0] CLR_ON_BOTH_ALT = 2'd3;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [CH_IDX_W-1:0]       i_channel;
    logic signed [LEVEL_W-1:0] i_cv_level;
    logic signed [LEVEL_W-1:0] i_sample_level;
    logic signed [LEVEL_W-1:0] i_update_level;
    logic signed [LEVEL_W-1:0] i_clear_level;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [CH_IDX_W-1:0]       o_out_channel;
    logic signed [LEVEL_W-1:0] o_out_level;
    logic                      o_count_reached;

    channel_level_tracker tracker = new();
    int                   requests_sent = 0;
    int                   settings_applied = 0;

    always #4 i_clk = ~i_clk;

    sample_update_trigger_counter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_channel       (i_channel),
        .i_cv_level      (i_cv_level),
        .i_sample_level  (i_sample_level),
        .i_update_level  (i_update_level),
        .i_clear_level   (i_clear_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_channel   (o_out_channel),
        .o_out_level     (o_out_level),
        .o_count_reached (o_count_reached)
    );

    // Pick a level at or above the high threshold, at or below the low one, or anywhere in range
    function automatic int pick_level(input int high_pct, input int low_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < high_pct) begin
            if ($urandom_range(0, 7) == 0) return tracker.det_hi;
            return tracker.det_hi + int'($urandom_range(0, LEVEL_MAX - tracker.det_hi));
        end
        if (roll < high_pct + low_pct) begin
            if ($urandom_range(0, 7) == 0) return tracker.det_lo;
            return -LEVEL_MAX + int'($urandom_range(0, tracker.det_lo + LEVEL_MAX));
        end
        return -LEVEL_MAX + int'($urandom_range(0, 2 * LEVEL_MAX));
    endfunction

    function automatic logic [2:0] policy_code(input logic [1:0] clr, input logic refresh);
        return {clr, refresh};
    endfunction

    task automatic send_request(input int ch, input int cv, input int s_lvl, input int u_lvl,
                                input int c_lvl);
        cv_request_t req;
        req.channel    = ch[CH_IDX_W-1:0];
        req.cv         = cv[LEVEL_W-1:0];
        req.sample_lvl = s_lvl[LEVEL_W-1:0];
        req.update_lvl = u_lvl[LEVEL_W-1:0];
        req.clear_lvl  = c_lvl[LEVEL_W-1:0];
        // Idle at random, except in the calm stretch
        if (requests_sent < 200 || requests_sent >= 300) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_channel      <= req.channel;
        i_cv_level     <= req.cv;
        i_sample_level <= req.sample_lvl;
        i_update_level <= req.update_lvl;
        i_clear_level  <= req.clear_lvl;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_request(req);
        requests_sent++;
    endtask

    // Drop valid and let every pending result drain
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (tracker.due_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [1:0] mode, input logic [2:0] style,
                                 input logic [2:0] pol, input int need, input int rst_lvl,
                                 input int lo, input int hi,
                                 input logic [CFG_DATA_W-1:0] levels);
        logic [CFG_DATA_W-1:0] vals [8];
        t_cfg_idx              idx;
        vals[CFG_OPERATING_MODE] = CFG_DATA_W'(mode);
        vals[CFG_CONTROL_STYLE]  = CFG_DATA_W'(style);
        vals[CFG_RESET_POLICY]   = CFG_DATA_W'(pol);
        vals[CFG_MIN_COUNT]      = CFG_DATA_W'(need);
        vals[CFG_RESET_LEVEL]    = CFG_DATA_W'(rst_lvl);
        vals[CFG_DETECT_LOW]     = CFG_DATA_W'(lo);
        vals[CFG_DETECT_HIGH]    = CFG_DATA_W'(hi);
        vals[CFG_OUT_LEVELS]     = levels;
        wait_for_results();
        // Hold valid across the whole burst of register writes
        idx = idx.first();
        do begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[idx];
            do @(posedge i_clk); while (!o_cfg_ready);
            tracker.write_reg(idx, vals[idx]);
            idx = idx.next();
        end while (idx != idx.first());
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Frames open with a channel 0 request, then other channels, with some stray channels
    task automatic run_frames(input int n_items, input int width);
        int left;
        int others;
        int ch;
        left = n_items;
        while (left > 0) begin
            send_request(0, pick_level(40, 40), pick_level(40, 45), pick_level(30, 55),
                         pick_level(15, 75));
            left--;
            others = $urandom_range(0, width - 1);
            while (others > 0 && left > 0) begin
                if ($urandom_range(0, 9) == 0) ch = $urandom_range(0, MAX_CHANNELS - 1);
                else ch = $urandom_range(1, width - 1);
                send_request(ch, pick_level(40, 40), pick_level(50, 50), pick_level(50, 50),
                             pick_level(50, 50));
                others--;
                left--;
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_channel      <= '0;
        i_cv_level     <= '0;
        i_sample_level <= '0;
        i_update_level <= '0;
        i_clear_level  <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_OPERATING_MODE;
        i_cfg_data     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Value hold at reset settings: sample, update, reset, thresholds hit exactly
        send_request(0, 16000, 16000, -16000, -16000);
        send_request(15, -16000, 0, 0, 0);
        send_request(0, 0, -16000, 16000, -16000);
        send_request(15, 12001, 0, 0, 0);
        send_request(0, 5, 1000, 100, 16000);
        send_request(7, -12001, 0, 0, 0);
        send_request(0, 999, 101, 999, 100);
        send_request(0, -1, 100, 1000, 1000);

        // Trigger count with level controls: count, fire, no retrigger, reset
        apply_setting(MODE_COUNT, 3'b111, policy_code(CLR_ON_BOTH, 1'b1), 2, -3000, 100, 1000,
                      RST_OUT_LEVELS);
        send_request(0, 16000, 16000, 0, 0);
        send_request(3, 16000, 0, 0, 0);
        send_request(0, -16000, 16000, 0, 0);
        send_request(0, 1000, 16000, 0, 0);
        send_request(0, 0, 0, 16000, 0);
        send_request(0, 0, 0, 16000, 0);
        send_request(3, 0, 0, 0, 0);
        send_request(0, 0, 0, 0, 16000);
        send_request(0, 0, 16000, 16000, 16000);

        // Random frames over a sweep of settings
        apply_setting(MODE_VALUE, 3'b000, policy_code(CLR_ON_BOTH, 1'b1), 1, 0, 100, 1000,
                      32'h2710_0000);
        run_frames(60, 16);
        apply_setting(MODE_GATE, 3'b111, policy_code(CLR_ON_RESET, 1'b0), 1, -16000, -16000,
                      16000, 32'h7FFF_8000);
        run_frames(40, 16);
        apply_setting(MODE_COUNT, 3'b000, policy_code(CLR_ON_UPDATE, 1'b0), 2, 16000, 100,
                      1000, 32'h2710_D8F0);
        run_frames(80, 2);
        apply_setting(MODE_COUNT, 3'b101, policy_code(CLR_ON_BOTH, 1'b0), 1, -500, -2000, 2000,
                      32'hFFFF_0000);
        run_frames(60, 3);
        apply_setting(MODE_GATE | MODE_COUNT, 3'b010, policy_code(CLR_ON_BOTH_ALT, 1'b0), 0, 0,
                      0, 0, 32'h8000_7FFF);
        run_frames(60, 2);
        apply_setting(MODE_COUNT, 3'b001, policy_code(CLR_ON_RESET, 1'b1), 31, 1234, 200, 800,
                      32'h0000_FFFF);
        run_frames(50, 1);
        apply_setting(MODE_VALUE, 3'b011, policy_code(CLR_ON_BOTH_ALT, 1'b1), 17, 16000, 16000,
                      -16000, 32'hFFFF_FFFF);
        run_frames(40, 16);
        apply_setting(MODE_GATE, 3'b100, policy_code(CLR_ON_UPDATE, 1'b1), 16, 5000, 500, 5000,
                      32'h1388_EC78);
        run_frames(40, 8);

        wait_for_results();
        $display("Sent %0d requests and checked %0d results over %0d register settings",
                 requests_sent, tracker.outputs_checked, settings_applied);
        $display("Covered value, gate and trigger count modes, edge and level controls, %0d %s",
                 tracker.mismatches, "mismatches");
        if (tracker.mismatches == 0 && tracker.due_outputs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int results_taken;
        int stall_left;
        bit stalled_once;
        results_taken = 0;
        stall_left    = 0;
        stalled_once  = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                tracker.check_result(o_out_channel, o_out_level, o_count_reached);
                results_taken++;
            end
            // Hold off once for a long stretch while requests keep coming
            if (!stalled_once && results_taken >= 120 && i_in_valid) begin
                stalled_once = 1'b1;
                stall_left   = 80;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (results_taken >= 200 && results_taken < 300) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin : stall_watch
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end
endmodule
